// ----- src/soh_frx_pkg.sv -----
// Shared types and constants for the SOH/STX length frame receiver.
package soh_frx_pkg;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_LEN   = 2'd1,
        PH_DATA  = 2'd2,
        PH_READY = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_CLEAR = 2'd1,
        KIND_READ  = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    localparam logic [7:0] SOH_BYTE = 8'h01;
    localparam logic [7:0] STX_BYTE = 8'h02;
    localparam logic [7:0] EOT_BYTE = 8'h04;

endpackage

// ----- src/soh_frx_buf.sv -----
// Payload buffer: one write port and one registered read port.
module soh_frx_buf
    import soh_frx_pkg::*;
#(
    parameter int DEPTH  = 32,
    parameter int ADDR_W = 5
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]        rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/soh_length_frame_receiver.sv -----
// Top level of the SOH/STX length frame receiver with its control and result stage.
// Each result is registered and appears in the cycle after its request is accepted.
// Throughput: one request per cycle unless a result waits with m_tready low; the output register
// and the buffer's registered read port let a new request enter while the last result is taken.
// Reset clears the phase, the frame length, the write position and the output
// valid flag; the payload buffer keeps its contents and is undefined until written.
module soh_length_frame_receiver
    import soh_frx_pkg::*;
#(
    parameter int MAX_PAYLOAD = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // rx_byte[7:0], read_index[12:8], zero[15:13]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // frame_ready[0], frame_length[6:1], read_data[14:7], zero[15]
);

    localparam int LEN_W  = $clog2(MAX_PAYLOAD + 1);
    localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    phase_t             phase_reg, phase_next;
    logic [LEN_W-1:0]   exp_len_reg, exp_len_next;
    logic [LEN_W-1:0]   wr_pos_reg, wr_pos_next;
    logic               valid_reg;
    logic               rd_sel_reg;

    logic               accept;
    kind_t              kind;
    logic [7:0]         rx_byte;
    logic [4:0]         read_index;
    logic               wr_en;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ADDR_W+4:0]  rd_addr_ext;
    logic [7:0]         buf_data;
    logic [LEN_W+5:0]   len_ext;
    logic [7:0]         read_data;

    assign kind       = kind_t'(s_tuser);
    assign rx_byte    = s_tdata[7:0];
    assign read_index = s_tdata[12:8];
    assign s_tready   = !valid_reg || m_tready;
    assign accept     = s_tvalid && s_tready;

    always_comb begin
        phase_next   = phase_reg;
        exp_len_next = exp_len_reg;
        wr_pos_next  = wr_pos_reg;
        if (accept) begin
            case (kind)
                KIND_BYTE: begin
                    case (phase_reg)
                        PH_DATA: begin
                            if (wr_pos_reg >= exp_len_reg) begin
                                phase_next = (rx_byte == EOT_BYTE) ? PH_READY : PH_IDLE;
                            end else begin
                                wr_pos_next = wr_pos_reg + 1'b1;
                            end
                        end
                        PH_LEN, PH_IDLE: begin
                            wr_pos_next = '0;
                            if (phase_reg == PH_LEN && rx_byte != 8'd0
                                && rx_byte <= 8'(MAX_PAYLOAD)) begin
                                phase_next   = PH_DATA;
                                exp_len_next = rx_byte[LEN_W-1:0];
                            end else begin
                                if (phase_reg == PH_LEN) begin
                                    exp_len_next = '0;
                                end
                                if (rx_byte == SOH_BYTE) begin
                                    phase_next   = PH_LEN;
                                    exp_len_next = LEN_W'(MAX_PAYLOAD);
                                end else if (rx_byte == STX_BYTE) begin
                                    phase_next   = PH_DATA;
                                    exp_len_next = LEN_W'(MAX_PAYLOAD);
                                end else begin
                                    phase_next = PH_IDLE;
                                end
                            end
                        end
                        default: begin
                            phase_next = phase_reg;
                        end
                    endcase
                end
                KIND_CLEAR: begin
                    phase_next = PH_IDLE;
                end
                default: begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_comb begin
        wr_en       = accept && kind == KIND_BYTE && phase_reg == PH_DATA
                      && wr_pos_reg < exp_len_reg;
        rd_en       = accept && kind == KIND_READ
                      && {3'b000, read_index} < 8'(MAX_PAYLOAD);
        rd_addr_ext = {{ADDR_W{1'b0}}, read_index};
        rd_addr     = rd_addr_ext[ADDR_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            exp_len_reg <= '0;
            wr_pos_reg  <= '0;
            valid_reg   <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            exp_len_reg <= exp_len_next;
            wr_pos_reg  <= wr_pos_next;
            if (accept) begin
                valid_reg <= 1'b1;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_sel_reg <= rd_en;
        end
    end

    soh_frx_buf #(
        .DEPTH  (MAX_PAYLOAD),
        .ADDR_W (ADDR_W)
    ) u_buf (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_pos_reg[ADDR_W-1:0]),
        .wr_data (rx_byte),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (buf_data)
    );

    assign len_ext   = {6'b000000, exp_len_reg};
    assign read_data = rd_sel_reg ? buf_data : 8'd0;
    assign m_tvalid  = valid_reg;
    assign m_tdata   = {1'b0, read_data, len_ext[5:0], phase_reg == PH_READY};

endmodule

// ----- tb/soh_length_frame_receiver_test.sv -----
// Self-checking testbench for the SOH/STX length frame receiver: directed, stall and random traffic.
module soh_length_frame_receiver_test
    import soh_frx_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_PAYLOAD = 32;
    localparam int RANDOM_REQUESTS = 1100;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic [7:0] data;
        logic [5:0] length;
        logic       ready;
    } frame_status_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;

    phase_t                 rx_phase = PH_IDLE;
    logic [5:0]             frame_len = '0;
    logic [5:0]             write_pos = '0;
    logic [7:0]             payload [MAX_PAYLOAD];
    logic [MAX_PAYLOAD-1:0] payload_valid = '0;

    frame_status_t status_queue[$];
    int            mismatch_count = 0;
    int            request_count = 0;
    int            cycle_count = 0;
    int            send_gap_max = 0;
    int            sink_gap_max = 0;
    int            sink_hold = 0;

    soh_length_frame_receiver #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("soh_length_frame_receiver_test: FAIL");
            $finish;
        end
    end

    function automatic frame_status_t next_frame_status(kind_t kind, logic [7:0] rx_byte,
                                                        logic [4:0] index);
        frame_status_t st;
        st.data = '0;
        if (kind == KIND_BYTE && rx_phase != PH_READY) begin
            if (rx_phase == PH_DATA) begin
                if (write_pos >= frame_len) begin
                    rx_phase = (rx_byte == EOT_BYTE) ? PH_READY : PH_IDLE;
                end else begin
                    payload[write_pos[4:0]] = rx_byte;
                    payload_valid[write_pos[4:0]] = 1'b1;
                    write_pos++;
                end
            end else begin
                if (rx_phase == PH_LEN) begin
                    if (rx_byte != 8'd0 && rx_byte <= 8'(MAX_PAYLOAD)) begin
                        rx_phase = PH_DATA;
                        frame_len = rx_byte[5:0];
                    end else begin
                        rx_phase = PH_IDLE;
                        frame_len = '0;
                    end
                    write_pos = '0;
                end
                if (rx_phase == PH_IDLE) begin
                    if (rx_byte == SOH_BYTE) begin
                        rx_phase = PH_LEN;
                        frame_len = 6'(MAX_PAYLOAD);
                    end else if (rx_byte == STX_BYTE) begin
                        rx_phase = PH_DATA;
                        frame_len = 6'(MAX_PAYLOAD);
                    end
                    write_pos = '0;
                end
            end
        end else if (kind == KIND_CLEAR) begin
            rx_phase = PH_IDLE;
        end else if (kind == KIND_READ) begin
            st.data = payload[index];
        end
        st.ready = (rx_phase == PH_READY);
        st.length = frame_len;
        return st;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        mismatch_count++;
        $display("%0t ns: %s mismatch: got %0d, expected %0d", $time, field, got, want);
    endtask

    always @(posedge aclk) begin
        frame_status_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (status_queue.size() == 0) begin
                report_mismatch("unexpected result", int'(m_tdata), 0);
            end else begin
                want = status_queue.pop_front();
                if (m_tdata[0] !== want.ready)
                    report_mismatch("frame_ready", int'(m_tdata[0]), int'(want.ready));
                if (m_tdata[6:1] !== want.length)
                    report_mismatch("frame_length", int'(m_tdata[6:1]), int'(want.length));
                if (m_tdata[14:7] !== want.data)
                    report_mismatch("read_data", int'(m_tdata[14:7]), int'(want.data));
            end
        end
    end

    initial begin : result_sink
        int pause;
        pause = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (sink_hold > 0) begin
                m_tready <= 1'b0;
                sink_hold--;
            end else if (pause > 0) begin
                m_tready <= 1'b0;
                pause--;
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
                while (!m_tvalid) @(posedge aclk);
                pause = $urandom_range(0, sink_gap_max);
            end
        end
    end

    // Entered at a falling edge; returns at the falling edge after the request is taken.
    task automatic send_request(input kind_t kind, input logic [7:0] rx_byte,
                                input logic [4:0] index);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {3'b000, index, rx_byte};
        s_tuser <= kind;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        status_queue.push_back(next_frame_status(kind, rx_byte, index));
        request_count++;
        @(negedge aclk);
    endtask

    task automatic send_byte(input logic [7:0] rx_byte);
        send_request(KIND_BYTE, rx_byte, 5'($urandom));
    endtask

    task automatic send_clear();
        send_request(KIND_CLEAR, 8'($urandom), 5'($urandom));
    endtask

    // Only entries written since reset are read back.
    task automatic send_read();
        logic [4:0] index;
        index = 5'($urandom);
        for (int i = 0; i < MAX_PAYLOAD && !payload_valid[index]; i++) index++;
        if (payload_valid[index])
            send_request(KIND_READ, 8'($urandom), index);
        else
            send_request(KIND_NONE, 8'($urandom), 5'($urandom));
    endtask

    task automatic send_frame(input bit fixed, input int length, input logic [7:0] last_byte);
        int count;
        count = fixed ? MAX_PAYLOAD : length;
        if (fixed) begin
            send_byte(STX_BYTE);
        end else begin
            send_byte(SOH_BYTE);
            send_byte(8'(length));
        end
        for (int i = 0; i < count; i++) send_byte(8'($urandom));
        send_byte(last_byte);
    endtask

    task automatic test_directed_frames();
        send_gap_max = 0;
        sink_gap_max = 0;
        send_frame(1'b0, 1, EOT_BYTE);
        send_byte(SOH_BYTE);
        send_request(KIND_READ, 8'h00, 5'd0);
        send_clear();
        send_frame(1'b0, 2, 8'h07);
        send_request(KIND_NONE, 8'hFF, 5'h1F);
        send_byte(SOH_BYTE);
        send_byte(8'h00);
        send_byte(SOH_BYTE);
        send_byte(8'h21);
        send_byte(SOH_BYTE);
        send_byte(8'h01);
        send_clear();
        send_byte(8'hFF);
        send_byte(STX_BYTE);
        send_clear();
    endtask

    task automatic test_output_stall();
        send_gap_max = 0;
        sink_gap_max = 0;
        sink_hold = HOLD_CYCLES;
        send_frame(1'b1, MAX_PAYLOAD, EOT_BYTE);
        repeat (4) send_read();
        send_clear();
    endtask

    task automatic test_random_traffic();
        int stop_at;
        int pick;
        int length;
        int k;
        stop_at = request_count + RANDOM_REQUESTS;
        while (request_count < stop_at) begin
            pick = $urandom_range(0, 3);
            send_gap_max = (pick == 0) ? 0 : 11;
            sink_gap_max = (pick == 1) ? 0 : 11;
            pick = $urandom_range(0, 9);
            length = $urandom_range(1, MAX_PAYLOAD);
            if (rx_phase != PH_IDLE && pick != 0) send_clear();
            case (pick)
                0, 1, 2, 3, 4: begin
                    send_frame($urandom_range(0, 3) == 0, length, EOT_BYTE);
                end
                5: begin
                    send_frame($urandom_range(0, 3) == 0, length, 8'($urandom));
                end
                6: begin
                    send_byte(SOH_BYTE);
                    send_byte(8'(length));
                    repeat ($urandom_range(0, length - 1)) send_byte(8'($urandom));
                    send_clear();
                end
                7: begin
                    send_byte(SOH_BYTE);
                    send_byte(($urandom_range(0, 3) == 0) ? 8'h00
                                                           : 8'($urandom_range(33, 255)));
                end
                default: begin
                    repeat ($urandom_range(1, 4)) begin
                        k = $urandom_range(0, 3);
                        if (kind_t'(k) == KIND_READ)
                            send_read();
                        else
                            send_request(kind_t'(k), 8'($urandom), 5'($urandom));
                    end
                end
            endcase
            repeat ($urandom_range(0, 3)) send_read();
            if (rx_phase == PH_READY && $urandom_range(0, 2) == 0) send_byte(8'($urandom));
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = KIND_BYTE;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed_frames();
        test_output_stall();
        test_random_traffic();

        s_tvalid <= 1'b0;
        while (status_queue.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0)
            $display("soh_length_frame_receiver_test: PASS");
        else
            $display("soh_length_frame_receiver_test: FAIL");
        $finish;
    end

endmodule
